/* design/pkvpa_pkg.sv */
// Shared types, codes and default sizes for the paged KV page allocator.
// No dependencies; every other design file imports this package.
package pkvpa_pkg;

    // Default sizes of the page pool and of the sequence table.
    localparam int POOL_PAGES_DEF        = 256;
    localparam int PAGE_TOKENS_DEF       = 16;
    localparam int MAX_SEQS_DEF          = 64;
    localparam int MAX_PAGES_PER_SEQ_DEF = 16;

    // Fixed widths of the request and result fields.
    localparam int REQ_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int TOKEN_W = 16;
    localparam int STAT_W  = 2;

    // Width of a page quotient from the ceiling divider.
    localparam int CDIV_W = TOKEN_W + 1;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_SHORT     = 2'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_META,
        ST_PREP,
        ST_ALLOC,
        ST_LIST
    } state_t;

endpackage

/* design/pkvpa_ceil_div.sv */
// Registered ceiling division of a token count by the page size.
// Depends on pkvpa_pkg for the token and quotient widths.
module pkvpa_ceil_div
    import pkvpa_pkg::*;
#(
    parameter int PAGE_TOKENS = PAGE_TOKENS_DEF
)
(
    input  logic              clk,
    input  logic [TOKEN_W-1:0] tokens,
    output logic [CDIV_W-1:0]  pages
);

    // The rounded-up numerator stays below 2^X_W; a reciprocal of SH fraction
    // bits, rounded up, gives the exact floor for every numerator of that size.
    localparam int X_W = TOKEN_W + 1;
    localparam int SH  = X_W + $clog2(PAGE_TOKENS);
    localparam int MUL = (1 << SH) / PAGE_TOKENS + 1;
    localparam int M_W = X_W + 2;
    localparam int P_W = X_W + M_W;

    logic [X_W-1:0]    num;
    logic [P_W-1:0]    prod;
    logic [P_W-1:0]    quot;
    logic [CDIV_W-1:0] pages_reg;

    // Multiply by the reciprocal and drop the fraction bits.
    always_comb
    begin
        num  = X_W'(tokens) + X_W'(PAGE_TOKENS - 1);
        prod = P_W'(num) * P_W'(MUL);
        quot = prod >> SH;
    end

    always_ff @(posedge clk)
    begin
        pages_reg <= CDIV_W'(quot);
    end

    assign pages = pages_reg;

endmodule

/* design/paged_kv_page_allocator.sv */
// Top level of the paged KV page allocator: sequencer, free stack, slot table
// and page lists. Depends on pkvpa_pkg and pkvpa_ceil_div.
//
//  Channel | Handshake                             | Payload
//  --------+---------------------------------------+---------------------------------
//  request | start, busy; taken at start && !busy  | req_type, seq_slot, token_count
//  result  | result_valid, one cycle per result    | status, page_valid, page_id,
//          |                                       | last, free_pages
//
// After the accept, an allocate of n pages keeps busy high through the slot
// table read, the divide and prepare, then one stack pop per cycle; a free
// or lookup of n pages through the slot table read, then one page list
// read per cycle. A malformed request or a slot out of range is answered
// without going busy. Results leave through an output register in the cycle
// after the work that makes them. Reset is ready at once: the free stack
// reads as its reset order through a low-water mark. The receiver cannot stall.
module paged_kv_page_allocator
    import pkvpa_pkg::*;
#(
    parameter int POOL_PAGES        = POOL_PAGES_DEF,
    parameter int PAGE_TOKENS       = PAGE_TOKENS_DEF,
    parameter int MAX_SEQS          = MAX_SEQS_DEF,
    parameter int MAX_PAGES_PER_SEQ = MAX_PAGES_PER_SEQ_DEF,
    localparam int PAGE_W = $clog2(POOL_PAGES),
    localparam int TOP_W  = $clog2(POOL_PAGES + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [SLOT_W-1:0]  seq_slot,
    input  logic [TOKEN_W-1:0] token_count,
    output logic               result_valid,
    output logic [STAT_W-1:0]  status,
    output logic               page_valid,
    output logic [PAGE_W-1:0]  page_id,
    output logic               last,
    output logic [TOP_W-1:0]   free_pages
);

    localparam int SIDX_W    = (MAX_SEQS > 1) ? $clog2(MAX_SEQS) : 1;
    localparam int CNT_W     = $clog2(MAX_PAGES_PER_SEQ + 1);
    localparam int LIST_N    = MAX_SEQS * MAX_PAGES_PER_SEQ;
    localparam int LIST_AW   = (LIST_N > 1) ? $clog2(LIST_N) : 1;
    localparam int META_W    = CNT_W + 1;

    // Sequencer and bookkeeping registers.
    state_t              state_reg, state_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [SIDX_W-1:0]   slot_idx_reg, slot_idx_next;
    logic [LIST_AW-1:0]  base_reg, base_next;
    logic [TOKEN_W-1:0]  tokens_reg, tokens_next;
    logic [TOP_W-1:0]    top_reg, top_next;
    logic [TOP_W-1:0]    low_reg, low_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    nfin_reg, nfin_next;
    logic                short_reg, short_next;
    logic [PAGE_W-1:0]   ptr_reg, ptr_next;
    logic                rd_init_reg, rd_init_next;
    logic [MAX_SEQS-1:0] slot_vld_reg, slot_vld_next;

    // Output registers.
    logic                result_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic                page_valid_reg;
    logic [PAGE_W-1:0]   page_id_reg;
    logic                last_reg;
    logic [TOP_W-1:0]    free_pages_reg;

    // Memories and their ports.
    logic [PAGE_W-1:0]   stack_mem [POOL_PAGES];
    logic [PAGE_W-1:0]   stack_q;
    logic                stack_re, stack_we;
    logic [PAGE_W-1:0]   stack_raddr, stack_waddr, stack_wdata;

    logic [META_W-1:0]   meta_mem [MAX_SEQS];
    logic [META_W-1:0]   meta_q;
    logic                meta_vld_q;
    logic                meta_re, meta_we;
    logic [SIDX_W-1:0]   meta_raddr;
    logic [META_W-1:0]   meta_wdata;

    logic [PAGE_W-1:0]   list_mem [LIST_N];
    logic [PAGE_W-1:0]   list_q;
    logic                list_re, list_we;
    logic [LIST_AW-1:0]  list_raddr, list_waddr;
    logic [PAGE_W-1:0]   list_wdata;

    // Result of this cycle, before the output register.
    logic                res_valid;
    logic [STAT_W-1:0]   res_status;
    logic                res_page_valid;
    logic [PAGE_W-1:0]   res_page;
    logic                res_last;

    // Shared decode.
    logic                req_known;
    logic                in_range;
    logic                meta_live;
    logic [CNT_W-1:0]    meta_cnt;
    logic [CDIV_W-1:0]   needed;
    logic [CNT_W-1:0]    cap;
    logic [CNT_W-1:0]    nfin_calc;
    logic                short_calc;
    logic                seq_last;
    logic [PAGE_W-1:0]   pop_page;

    pkvpa_ceil_div #(
        .PAGE_TOKENS (PAGE_TOKENS)
    ) u_ceil_div (
        .clk    (clk),
        .tokens (tokens_reg),
        .pages  (needed)
    );

    // Decode of the request, the slot entry and the page budget.
    always_comb
    begin
        req_known  = (req_type == REQ_ALLOC) || (req_type == REQ_FREE) ||
                     (req_type == REQ_LOOKUP);
        in_range   = (32'(seq_slot) < MAX_SEQS);
        meta_live  = meta_vld_q & meta_q[CNT_W];
        meta_cnt   = meta_q[CNT_W-1:0];
        cap        = (32'(top_reg) < MAX_PAGES_PER_SEQ) ? CNT_W'(top_reg)
                                                        : CNT_W'(MAX_PAGES_PER_SEQ);
        nfin_calc  = (32'(needed) < 32'(cap)) ? CNT_W'(needed) : cap;
        short_calc = (32'(nfin_calc) < 32'(needed));
        seq_last   = ((cnt_reg + CNT_W'(1)) == nfin_reg);
        pop_page   = rd_init_reg ? ptr_reg : stack_q;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && req_known && in_range)
                    state_next = ST_META;
            end
            ST_META:
            begin
                if (req_reg == REQ_ALLOC)
                    state_next = ST_PREP;
                else if (!meta_live || meta_cnt == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_LIST;
            end
            ST_PREP:
            begin
                if (nfin_calc == '0)
                    state_next = ST_IDLE;
                else
                    state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                if (seq_last)
                    state_next = ST_IDLE;
            end
            ST_LIST:
            begin
                if (seq_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and results for each state.
    always_comb
    begin
        req_next       = req_reg;
        slot_idx_next  = slot_idx_reg;
        base_next      = base_reg;
        tokens_next    = tokens_reg;
        top_next       = top_reg;
        low_next       = low_reg;
        cnt_next       = cnt_reg;
        nfin_next      = nfin_reg;
        short_next     = short_reg;
        ptr_next       = ptr_reg;
        rd_init_next   = rd_init_reg;
        slot_vld_next  = slot_vld_reg;

        stack_re       = 1'b0;
        stack_raddr    = ptr_reg;
        stack_we       = 1'b0;
        stack_waddr    = PAGE_W'(top_reg);
        stack_wdata    = list_q;
        meta_re        = 1'b0;
        meta_raddr     = SIDX_W'(seq_slot);
        meta_we        = 1'b0;
        meta_wdata     = '0;
        list_re        = 1'b0;
        list_raddr     = base_reg + LIST_AW'(cnt_reg);
        list_we        = 1'b0;
        list_waddr     = base_reg + LIST_AW'(cnt_reg);
        list_wdata     = pop_page;

        res_valid      = 1'b0;
        res_status     = STAT_OK;
        res_page_valid = 1'b0;
        res_page       = '0;
        res_last       = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Latch the transaction; stray requests are answered at once.
                if (start)
                begin
                    req_next      = req_type;
                    slot_idx_next = SIDX_W'(seq_slot);
                    base_next     = LIST_AW'(32'(seq_slot) * MAX_PAGES_PER_SEQ);
                    tokens_next   = token_count;
                    if (!req_known)
                    begin
                        res_valid = 1'b1;
                    end
                    else if (!in_range)
                    begin
                        res_valid  = 1'b1;
                        res_status = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        meta_re = 1'b1;
                    end
                end
            end
            ST_META:
            begin
                // Slot entry is back; free and lookup decide here.
                cnt_next  = '0;
                nfin_next = meta_cnt;
                if (req_reg != REQ_ALLOC)
                begin
                    if (!meta_live)
                    begin
                        res_valid  = 1'b1;
                        res_status = STAT_NOT_FOUND;
                    end
                    else if (meta_cnt == '0)
                    begin
                        res_valid = 1'b1;
                        if (req_reg == REQ_FREE)
                            meta_we = 1'b1;
                    end
                    else
                    begin
                        list_re    = 1'b1;
                        list_raddr = base_reg;
                    end
                end
            end
            ST_PREP:
            begin
                // Page budget is known; start popping or answer an empty list.
                cnt_next   = '0;
                nfin_next  = nfin_calc;
                short_next = short_calc;
                if (nfin_calc == '0)
                begin
                    res_valid  = 1'b1;
                    res_status = short_calc ? STAT_SHORT : STAT_OK;
                    meta_we    = 1'b1;
                    meta_wdata = {1'b1, CNT_W'(0)};
                end
                else
                begin
                    stack_re     = 1'b1;
                    stack_raddr  = PAGE_W'(top_reg - TOP_W'(1));
                    ptr_next     = PAGE_W'(top_reg - TOP_W'(1));
                    rd_init_next = ((top_reg - TOP_W'(1)) < low_reg);
                    top_next     = top_reg - TOP_W'(nfin_calc);
                end
            end
            ST_ALLOC:
            begin
                // One popped page per cycle: record it and report it.
                res_valid      = 1'b1;
                res_status     = short_reg ? STAT_SHORT : STAT_OK;
                res_page_valid = 1'b1;
                res_page       = pop_page;
                res_last       = seq_last;
                list_we        = 1'b1;
                if (seq_last)
                begin
                    meta_we    = 1'b1;
                    meta_wdata = {1'b1, nfin_reg};
                    low_next   = (top_reg < low_reg) ? top_reg : low_reg;
                end
                else
                begin
                    stack_re     = 1'b1;
                    stack_raddr  = ptr_reg - PAGE_W'(1);
                    ptr_next     = ptr_reg - PAGE_W'(1);
                    rd_init_next = (TOP_W'(ptr_reg - PAGE_W'(1)) < low_reg);
                    cnt_next     = cnt_reg + CNT_W'(1);
                end
            end
            ST_LIST:
            begin
                // One list entry per cycle: push it back or report it.
                if (req_reg == REQ_FREE)
                begin
                    if (32'(top_reg) < POOL_PAGES)
                    begin
                        stack_we = 1'b1;
                        top_next = top_reg + TOP_W'(1);
                    end
                    if (seq_last)
                    begin
                        res_valid = 1'b1;
                        meta_we   = 1'b1;
                    end
                end
                else
                begin
                    res_valid      = 1'b1;
                    res_page_valid = 1'b1;
                    res_page       = list_q;
                    res_last       = seq_last;
                end
                if (!seq_last)
                begin
                    list_re    = 1'b1;
                    list_raddr = base_reg + LIST_AW'(cnt_reg) + LIST_AW'(1);
                    cnt_next   = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase

        if (meta_we)
            slot_vld_next[slot_idx_reg] = 1'b1;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            top_reg          <= TOP_W'(POOL_PAGES);
            low_reg          <= TOP_W'(POOL_PAGES);
            slot_vld_reg     <= '0;
            cnt_reg          <= '0;
            nfin_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            top_reg          <= top_next;
            low_reg          <= low_next;
            slot_vld_reg     <= slot_vld_next;
            cnt_reg          <= cnt_next;
            nfin_reg         <= nfin_next;
            result_valid_reg <= res_valid;
        end
    end

    // Transaction payload and result payload registers.
    always_ff @(posedge clk)
    begin
        req_reg        <= req_next;
        slot_idx_reg   <= slot_idx_next;
        base_reg       <= base_next;
        tokens_reg     <= tokens_next;
        short_reg      <= short_next;
        ptr_reg        <= ptr_next;
        rd_init_reg    <= rd_init_next;
        status_reg     <= res_status;
        page_valid_reg <= res_page_valid;
        page_id_reg    <= res_page;
        last_reg       <= res_last;
        free_pages_reg <= top_next;
    end

    // Free stack memory.
    always_ff @(posedge clk)
    begin
        if (stack_we)
            stack_mem[stack_waddr] <= stack_wdata;
        if (stack_re)
            stack_q <= stack_mem[stack_raddr];
    end

    // Slot table memory: live flag and page count.
    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[slot_idx_reg] <= meta_wdata;
        if (meta_re)
        begin
            meta_q     <= meta_mem[meta_raddr];
            meta_vld_q <= slot_vld_reg[meta_raddr];
        end
    end

    // Page list memory.
    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[list_waddr] <= list_wdata;
        if (list_re)
            list_q <= list_mem[list_raddr];
    end

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign status       = status_reg;
    assign page_valid   = page_valid_reg;
    assign page_id      = page_id_reg;
    assign last         = last_reg;
    assign free_pages   = free_pages_reg;

`ifndef SYNTH
    // The final result of a transaction leaves with the sequencer idle.
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
        else $error("final result while still busy");

    // An accepted transaction is either answered at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || (result_valid && last))
        else $error("accepted transaction neither answered nor in progress");

    // Results of one transaction come in back-to-back cycles.
    a_results_packed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("gap inside a multi-result transaction");

    // The free count reported with a result never exceeds the pool.
    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> 32'(free_pages) <= POOL_PAGES)
        else $error("free page count above pool size");
`endif

endmodule
